/* rtl/qch_pkg.sv */
// ============================================================================
// qch_pkg - shared types and constants
// Types, fixed constants and small helpers of the curve hull vertex block.
// ============================================================================
package qch_pkg;

    // internal datapath width, holds every rotated or grown coordinate
    localparam int DW          = 40;
    localparam int CORD_STEPS  = 32;
    localparam int GAIN_W      = 26;
    localparam int GAIN_SHIFT  = 26;
    localparam logic [GAIN_W-1:0] INV_GAIN = 26'd40752055;
    localparam int NUM_VERTS   = 6;
    localparam int NUM_CORNERS = 4;
    localparam int CNT_W       = 3;
    localparam logic [CNT_W-1:0] LAST_VERT = 3'd5;
    localparam logic [30:0] MARGIN_RESET = 31'd65536;

    // per-item sideband that travels with the datapath
    typedef struct packed {
        logic signed [31:0]    sx;
        logic signed [31:0]    sy;
        logic signed [31:0]    cx;
        logic signed [31:0]    cy;
        logic signed [31:0]    ex;
        logic signed [31:0]    ey;
        logic [30:0]           lw;
        logic [31:0]           rgba;
        logic [1:0]            caps;
        logic                  flip;
        logic                  rot;
        logic [CORD_STEPS-1:0] dirs;
    } t_meta;

    // how the derivative root is picked
    typedef enum logic [1:0] {
        T_ZERO,
        T_ONE,
        T_DIV
    } t_tsel;

    // corner index for each vertex of the two triangles
    function automatic logic [1:0] corner_of(input logic [CNT_W-1:0] cnt);
        logic [1:0] c;
        case (cnt)
            3'd0: c = 2'd0;
            3'd1: c = 2'd1;
            3'd2: c = 2'd2;
            3'd3: c = 2'd2;
            3'd4: c = 2'd1;
            3'd5: c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [DW-1:0] min3(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b,
                                                  input logic signed [DW-1:0] c);
        logic signed [DW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [DW-1:0] max3(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b,
                                                  input logic signed [DW-1:0] c);
        logic signed [DW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

/* rtl/qch_if.sv */
// ============================================================================
// qch_if - channel interfaces
// Curve input, vertex output and margin register write channels.
// ============================================================================

// curve input channel
interface qch_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] ctrl_x;
    logic signed [31:0] ctrl_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [30:0]        line_width;
    logic [31:0]        rgba;
    logic [1:0]         caps;

    modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                    line_width, rgba, caps, input ready);
    modport sink   (input valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                    line_width, rgba, caps, output ready);
endinterface

// hull vertex output channel
interface qch_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] out_start_x;
    logic signed [31:0] out_start_y;
    logic signed [31:0] out_ctrl_x;
    logic signed [31:0] out_ctrl_y;
    logic signed [31:0] out_end_x;
    logic signed [31:0] out_end_y;
    logic signed [31:0] start_width;
    logic signed [31:0] end_width;
    logic [31:0]        out_rgba;
    logic               last;

    modport source (output valid, vert_x, vert_y, out_start_x, out_start_y, out_ctrl_x,
                    out_ctrl_y, out_end_x, out_end_y, start_width, end_width,
                    out_rgba, last, input ready);
    modport sink   (input valid, vert_x, vert_y, out_start_x, out_start_y, out_ctrl_x,
                    out_ctrl_y, out_end_x, out_end_y, start_width, end_width,
                    out_rgba, last, output ready);
endinterface

// margin register write channel
interface qch_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] hull_margin;

    modport source (output valid, hull_margin, input ready);
    modport sink   (input valid, hull_margin, output ready);
endinterface

/* rtl/qch_cordic.sv */
// ============================================================================
// qch_cordic - pipelined shift-add rotator
// One micro-rotation per stage over NV vectors, then a two-stage gain
// correction. Vectoring mode steers by lane 0 and records the directions,
// rotating mode replays the recorded directions in the opposite sense.
// ============================================================================
module qch_cordic #(
    parameter int NV   = 2,
    parameter bit VECT = 1'b1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  qch_pkg::t_meta             i_meta,
    input  logic signed [qch_pkg::DW-1:0] i_x [NV],
    input  logic signed [qch_pkg::DW-1:0] i_y [NV],
    output logic                       o_valid,
    output qch_pkg::t_meta             o_meta,
    output logic signed [qch_pkg::DW-1:0] o_x [NV],
    output logic signed [qch_pkg::DW-1:0] o_y [NV]
);

    localparam int DW  = qch_pkg::DW;
    localparam int NS  = qch_pkg::CORD_STEPS;
    localparam int GW  = qch_pkg::GAIN_W;
    localparam int LW  = 20;
    localparam int HW  = DW - LW;
    localparam int SW  = HW + GW + LW + 2;
    localparam logic signed [SW-1:0] RND = SW'(1) <<< (qch_pkg::GAIN_SHIFT - 1);

    logic signed [DW-1:0] r_x [NS][NV];
    logic signed [DW-1:0] r_y [NS][NV];
    qch_pkg::t_meta       r_m [NS];
    logic [NS-1:0]        r_v;

    logic signed [DW-1:0] n_x [NS][NV];
    logic signed [DW-1:0] n_y [NS][NV];
    qch_pkg::t_meta       n_m [NS];

    // micro-rotation of every stage
    always_comb begin
        logic signed [DW-1:0] px [NV];
        logic signed [DW-1:0] py [NV];
        qch_pkg::t_meta       pm;
        logic                 cw;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                px = i_x;
                py = i_y;
                pm = i_meta;
            end else begin
                px = r_x[k-1];
                py = r_y[k-1];
                pm = r_m[k-1];
            end
            n_m[k] = pm;
            if (VECT) begin
                cw = ~py[0][DW-1];
                n_m[k].dirs[k] = cw;
            end else begin
                cw = ~pm.dirs[k];
            end
            for (int l = 0; l < NV; l++) begin
                if (!pm.rot) begin
                    n_x[k][l] = px[l];
                    n_y[k][l] = py[l];
                end else if (cw) begin
                    n_x[k][l] = px[l] + (py[l] >>> k);
                    n_y[k][l] = py[l] - (px[l] >>> k);
                end else begin
                    n_x[k][l] = px[l] - (py[l] >>> k);
                    n_y[k][l] = py[l] + (px[l] >>> k);
                end
            end
        end
    end

    // valid bits of the rotation stages and both gain stages
    logic r_gv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_gv    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[NS-2:0], i_valid};
            r_gv    <= r_v[NS-1];
            o_valid <= r_gv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_m[k] <= n_m[k];
            end
        end
    end

    // gain stage 1: split partial products
    logic signed [DW-1:0]     r_gx [NV];
    logic signed [DW-1:0]     r_gy [NV];
    logic [LW+GW-1:0]         r_plx [NV];
    logic [LW+GW-1:0]         r_ply [NV];
    logic signed [HW+GW:0]    r_phx [NV];
    logic signed [HW+GW:0]    r_phy [NV];
    qch_pkg::t_meta           r_gm;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gm <= r_m[NS-1];
            for (int l = 0; l < NV; l++) begin
                r_gx[l]  <= r_x[NS-1][l];
                r_gy[l]  <= r_y[NS-1][l];
                r_plx[l] <= (LW+GW)'(r_x[NS-1][l][LW-1:0]) * (LW+GW)'(qch_pkg::INV_GAIN);
                r_ply[l] <= (LW+GW)'(r_y[NS-1][l][LW-1:0]) * (LW+GW)'(qch_pkg::INV_GAIN);
                r_phx[l] <= $signed(r_x[NS-1][l][DW-1:LW]) *
                            $signed({1'b0, qch_pkg::INV_GAIN});
                r_phy[l] <= $signed(r_y[NS-1][l][DW-1:LW]) *
                            $signed({1'b0, qch_pkg::INV_GAIN});
            end
        end
    end

    // gain stage 2: sum, round half up, floor shift; unrotated items pass through
    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        if (i_en) begin
            o_meta <= r_gm;
            for (int l = 0; l < NV; l++) begin
                sx = (SW'(r_phx[l]) <<< LW) + $signed({{(SW-LW-GW){1'b0}}, r_plx[l]}) + RND;
                sy = (SW'(r_phy[l]) <<< LW) + $signed({{(SW-LW-GW){1'b0}}, r_ply[l]}) + RND;
                if (r_gm.rot) begin
                    o_x[l] <= sx[qch_pkg::GAIN_SHIFT +: DW];
                    o_y[l] <= sy[qch_pkg::GAIN_SHIFT +: DW];
                end else begin
                    o_x[l] <= r_gx[l];
                    o_y[l] <= r_gy[l];
                end
            end
        end
    end

endmodule

/* rtl/qch_extreme.sv */
// ============================================================================
// qch_extreme - curve extreme on one axis
// Finds the clamped derivative root with a radix-2 restoring divider,
// one quotient bit per stage, and evaluates the curve there.
// ============================================================================
module qch_extreme #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [qch_pkg::DW-1:0] i_q1,
    input  logic signed [qch_pkg::DW-1:0] i_q2,
    output logic signed [qch_pkg::DW-1:0] o_m,
    output logic signed [qch_pkg::DW-1:0] o_q2
);

    localparam int DW = qch_pkg::DW;
    localparam int EW = DW + 2;
    localparam int FB = FRAC_BITS;
    localparam int TW = FB + 1;
    localparam int PW = DW + TW + 1;
    localparam logic [TW-1:0] ONE = TW'(1) << FB;

    // classify the ratio and take magnitudes
    logic [DW-1:0]        r_c_an, r_c_ad;
    qch_pkg::t_tsel       r_c_sel;
    logic signed [DW-1:0] r_c_q1, r_c_q2;

    always_ff @(posedge i_clk) begin
        logic signed [EW-1:0] num, den, an, ad;
        if (i_en) begin
            num = -EW'(i_q1);
            den = EW'(i_q2) - (EW'(i_q1) <<< 1);
            an  = num[EW-1] ? -num : num;
            ad  = den[EW-1] ? -den : den;
            if (den == '0 || num == '0 || (num[EW-1] != den[EW-1])) begin
                r_c_sel <= qch_pkg::T_ZERO;
            end else if (an >= ad) begin
                r_c_sel <= qch_pkg::T_ONE;
            end else begin
                r_c_sel <= qch_pkg::T_DIV;
            end
            r_c_an <= an[DW-1:0];
            r_c_ad <= ad[DW-1:0];
            r_c_q1 <= i_q1;
            r_c_q2 <= i_q2;
        end
    end

    // divider stages, one quotient bit each
    logic [DW-1:0]        r_rem [FB];
    logic [DW-1:0]        r_dad [FB];
    logic [FB-1:0]        r_quo [FB];
    qch_pkg::t_tsel       r_dsel [FB];
    logic signed [DW-1:0] r_dq1 [FB];
    logic signed [DW-1:0] r_dq2 [FB];

    always_ff @(posedge i_clk) begin
        logic [DW:0]   s, d;
        logic [DW-1:0] prem, pad;
        logic [FB-1:0] pquo;
        if (i_en) begin
            for (int k = 0; k < FB; k++) begin
                if (k == 0) begin
                    prem = r_c_an;
                    pad  = r_c_ad;
                    pquo = '0;
                    r_dsel[k] <= r_c_sel;
                    r_dq1[k]  <= r_c_q1;
                    r_dq2[k]  <= r_c_q2;
                end else begin
                    prem = r_rem[k-1];
                    pad  = r_dad[k-1];
                    pquo = r_quo[k-1];
                    r_dsel[k] <= r_dsel[k-1];
                    r_dq1[k]  <= r_dq1[k-1];
                    r_dq2[k]  <= r_dq2[k-1];
                end
                s = {prem, 1'b0};
                d = s - {1'b0, pad};
                r_dad[k] <= pad;
                if (s >= {1'b0, pad}) begin
                    r_rem[k] <= d[DW-1:0];
                    r_quo[k] <= {pquo[FB-2:0], 1'b1};
                end else begin
                    r_rem[k] <= s[DW-1:0];
                    r_quo[k] <= {pquo[FB-2:0], 1'b0};
                end
            end
        end
    end

    // pick t and its complement
    logic [TW-1:0]        r_t, r_u;
    logic signed [DW-1:0] r_tq1, r_tq2;

    always_ff @(posedge i_clk) begin
        logic [TW-1:0] t;
        if (i_en) begin
            case (r_dsel[FB-1])
                qch_pkg::T_ZERO: t = '0;
                qch_pkg::T_ONE:  t = ONE;
                qch_pkg::T_DIV:  t = {1'b0, r_quo[FB-1]};
                default:         t = '0;
            endcase
            r_t   <= t;
            r_u   <= ONE - t;
            r_tq1 <= r_dq1[FB-1];
            r_tq2 <= r_dq2[FB-1];
        end
    end

    // bernstein weights
    logic [TW-1:0]        r_w1, r_w2;
    logic signed [DW-1:0] r_wq1, r_wq2;

    always_ff @(posedge i_clk) begin
        logic [2*TW-1:0] ut, tt;
        if (i_en) begin
            ut = (2*TW)'(r_u) * (2*TW)'(r_t);
            tt = (2*TW)'(r_t) * (2*TW)'(r_t);
            r_w1  <= ut[FB-1 +: TW];
            r_w2  <= tt[FB +: TW];
            r_wq1 <= r_tq1;
            r_wq2 <= r_tq2;
        end
    end

    // weighted points
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [DW-1:0] r_pq2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= PW'(r_wq1) * PW'($signed({1'b0, r_w1}));
            r_p2  <= PW'(r_wq2) * PW'($signed({1'b0, r_w2}));
            r_pq2 <= r_wq2;
        end
    end

    // sum and floor shift
    always_ff @(posedge i_clk) begin
        logic signed [PW:0] s;
        if (i_en) begin
            s = (PW+1)'(r_p1) + (PW+1)'(r_p2);
            o_m  <= s[FB +: DW];
            o_q2 <= r_pq2;
        end
    end

endmodule

/* rtl/quadratic_curve_hull_vertices_core.sv */
// ============================================================================
// quadratic_curve_hull_vertices_core - stroked curve hull generator
// Turns one quadratic curve into six triangle-list vertices of its
// oriented, grown bounding box.
// ============================================================================
// Usage:
//   i_curve carries one curve per transfer (three points, width, color,
//   caps). o_vert returns six vertex transfers per curve, corners in order
//   0,1,2,2,1,3, with last set on the sixth. i_cfg writes hull_margin; it is
//   always ready; the user must write it only while no curve is in flight,
//   which the block does not enforce. A curve passes the input stage, forward
//   rotator, extreme pipeline, box stage, back rotator, final stage and vertex
//   register; its other vertices follow one per cycle while o_vert.ready is set.
// Throughput: the pipeline takes one curve per cycle until it fills; the
//   vertex port then sets the sustained rate. Depth is set by the two
//   rotators of 32 micro-rotation stages and the FRAC_BITS-stage divider.
// Reset: all valid bits clear, hull_margin returns to 1.0.
// Stall: while o_vert.ready is low the vertex register holds, and once the
//   last pipeline stage is full the whole pipeline freezes and i_curve.ready
//   drops; nothing is dropped or repeated.
// ============================================================================
module quadratic_curve_hull_vertices_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qch_in_if.sink    i_curve,
    qch_cfg_if.sink   i_cfg,
    qch_out_if.source o_vert
);

    localparam int DW = qch_pkg::DW;
    localparam int NC = qch_pkg::NUM_CORNERS;
    localparam int EL = FRAC_BITS + 5;
    localparam logic signed [DW-1:0] SMAX = DW'(2147483647);
    localparam logic signed [DW-1:0] SMIN = -SMAX - DW'(1);

    logic pipe_en;
    logic ser_load;
    logic out_fire;

    // margin register
    logic [30:0] r_margin;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= qch_pkg::MARGIN_RESET;
        end else if (i_cfg.valid) begin
            r_margin <= i_cfg.hull_margin;
        end
    end

    assign i_curve.ready = pipe_en;

    // input stage: chord vectors, half turn when end lies left of start
    logic                 r_a_v;
    qch_pkg::t_meta       r_a_m;
    logic signed [DW-1:0] r_a_x [2];
    logic signed [DW-1:0] r_a_y [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (pipe_en) begin
            r_a_v <= i_curve.valid;
        end
    end

    // lane 0 carries the chord, which steers the rotation; lane 1 the control point
    always_ff @(posedge i_clk) begin
        logic signed [32:0] ax, ay, bx, by;
        logic               flip;
        if (pipe_en) begin
            ax   = 33'(i_curve.ctrl_x) - 33'(i_curve.start_x);
            ay   = 33'(i_curve.ctrl_y) - 33'(i_curve.start_y);
            bx   = 33'(i_curve.end_x) - 33'(i_curve.start_x);
            by   = 33'(i_curve.end_y) - 33'(i_curve.start_y);
            flip = bx[32];
            if (flip) begin
                ax = -ax;
                ay = -ay;
                bx = -bx;
                by = -by;
            end
            r_a_x[0]   <= DW'(bx);
            r_a_y[0]   <= DW'(by);
            r_a_x[1]   <= DW'(ax);
            r_a_y[1]   <= DW'(ay);
            r_a_m.sx   <= i_curve.start_x;
            r_a_m.sy   <= i_curve.start_y;
            r_a_m.cx   <= i_curve.ctrl_x;
            r_a_m.cy   <= i_curve.ctrl_y;
            r_a_m.ex   <= i_curve.end_x;
            r_a_m.ey   <= i_curve.end_y;
            r_a_m.lw   <= i_curve.line_width;
            r_a_m.rgba <= i_curve.rgba;
            r_a_m.caps <= i_curve.caps;
            r_a_m.flip <= flip;
            r_a_m.rot  <= (bx != '0) || (by != '0);
            r_a_m.dirs <= '0;
        end
    end

    // align chord with the x axis
    logic                 fwd_v;
    qch_pkg::t_meta       fwd_m;
    logic signed [DW-1:0] fwd_x [2];
    logic signed [DW-1:0] fwd_y [2];

    qch_cordic #(.NV(2), .VECT(1'b1)) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_a_v),
        .i_meta  (r_a_m),
        .i_x     (r_a_x),
        .i_y     (r_a_y),
        .o_valid (fwd_v),
        .o_meta  (fwd_m),
        .o_x     (fwd_x),
        .o_y     (fwd_y)
    );

    // curve extremes per axis
    logic signed [DW-1:0] mx, my, q2x, q2y;

    qch_extreme #(.FRAC_BITS(FRAC_BITS)) u_ext_x (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_q1  (fwd_x[1]),
        .i_q2  (fwd_x[0]),
        .o_m   (mx),
        .o_q2  (q2x)
    );

    qch_extreme #(.FRAC_BITS(FRAC_BITS)) u_ext_y (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_q1  (fwd_y[1]),
        .i_q2  (fwd_y[0]),
        .o_m   (my),
        .o_q2  (q2y)
    );

    // sideband alongside the extreme pipeline
    qch_pkg::t_meta r_em [EL];
    logic [EL-1:0]  r_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
        end else if (pipe_en) begin
            r_ev <= {r_ev[EL-2:0], fwd_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_em[0] <= fwd_m;
            for (int k = 1; k < EL; k++) begin
                r_em[k] <= r_em[k-1];
            end
        end
    end

    // grown box corners
    logic                 r_b_v;
    qch_pkg::t_meta       r_b_m;
    logic signed [DW-1:0] r_b_x [NC];
    logic signed [DW-1:0] r_b_y [NC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (pipe_en) begin
            r_b_v <= r_ev[EL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [DW-1:0] grow, lox, hix, loy, hiy;
        if (pipe_en) begin
            grow = DW'($signed({1'b0, r_em[EL-1].lw})) + DW'($signed({1'b0, r_margin}));
            lox  = qch_pkg::min3(mx, '0, q2x) - grow;
            hix  = qch_pkg::max3(mx, '0, q2x) + grow;
            loy  = qch_pkg::min3(my, '0, q2y) - grow;
            hiy  = qch_pkg::max3(my, '0, q2y) + grow;
            r_b_m    <= r_em[EL-1];
            r_b_x[0] <= lox;  r_b_y[0] <= loy;
            r_b_x[1] <= hix;  r_b_y[1] <= loy;
            r_b_x[2] <= lox;  r_b_y[2] <= hiy;
            r_b_x[3] <= hix;  r_b_y[3] <= hiy;
        end
    end

    // rotate corners back
    logic                 bck_v;
    qch_pkg::t_meta       bck_m;
    logic signed [DW-1:0] bck_x [NC];
    logic signed [DW-1:0] bck_y [NC];

    qch_cordic #(.NV(NC), .VECT(1'b0)) u_bck (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_b_v),
        .i_meta  (r_b_m),
        .i_x     (r_b_x),
        .i_y     (r_b_y),
        .o_valid (bck_v),
        .o_meta  (bck_m),
        .o_x     (bck_x),
        .o_y     (bck_y)
    );

    // undo half turn, shift back, saturate
    logic               r_f_v;
    qch_pkg::t_meta     r_f_m;
    logic signed [31:0] r_f_x [NC];
    logic signed [31:0] r_f_y [NC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (pipe_en) begin
            r_f_v <= bck_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [DW-1:0] vx, vy;
        if (pipe_en) begin
            r_f_m <= bck_m;
            for (int c = 0; c < NC; c++) begin
                vx = (bck_m.flip ? -bck_x[c] : bck_x[c]) + DW'(bck_m.sx);
                vy = (bck_m.flip ? -bck_y[c] : bck_y[c]) + DW'(bck_m.sy);
                r_f_x[c] <= (vx > SMAX) ? 32'sh7fffffff :
                            (vx < SMIN) ? 32'sh80000000 : vx[31:0];
                r_f_y[c] <= (vy > SMAX) ? 32'sh7fffffff :
                            (vy < SMIN) ? 32'sh80000000 : vy[31:0];
            end
        end
    end

    // vertex serializer
    logic                      r_o_valid;
    logic [qch_pkg::CNT_W-1:0] r_cnt;
    qch_pkg::t_meta            r_o_m;
    logic signed [31:0]        r_o_x [NC];
    logic signed [31:0]        r_o_y [NC];
    logic [1:0]                corner;
    logic signed [31:0]        lw32;

    assign out_fire = r_o_valid && o_vert.ready;
    assign ser_load = r_f_v && (!r_o_valid || (out_fire && r_cnt == qch_pkg::LAST_VERT));
    assign pipe_en  = !r_f_v || ser_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (ser_load) begin
                r_o_valid <= 1'b1;
            end else if (out_fire && r_cnt == qch_pkg::LAST_VERT) begin
                r_o_valid <= 1'b0;
            end
            if (out_fire) begin
                r_cnt <= (r_cnt == qch_pkg::LAST_VERT) ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_o_m <= r_f_m;
            r_o_x <= r_f_x;
            r_o_y <= r_f_y;
        end
    end

    // vertex fields
    assign corner = qch_pkg::corner_of(r_cnt);
    assign lw32   = $signed({1'b0, r_o_m.lw});

    assign o_vert.valid       = r_o_valid;
    assign o_vert.vert_x      = r_o_x[corner];
    assign o_vert.vert_y      = r_o_y[corner];
    assign o_vert.out_start_x = r_o_m.sx;
    assign o_vert.out_start_y = r_o_m.sy;
    assign o_vert.out_ctrl_x  = r_o_m.cx;
    assign o_vert.out_ctrl_y  = r_o_m.cy;
    assign o_vert.out_end_x   = r_o_m.ex;
    assign o_vert.out_end_y   = r_o_m.ey;
    assign o_vert.start_width = r_o_m.caps[0] ? lw32 : -lw32;
    assign o_vert.end_width   = r_o_m.caps[1] ? lw32 : -lw32;
    assign o_vert.out_rgba    = r_o_m.rgba;
    assign o_vert.last        = (r_cnt == qch_pkg::LAST_VERT);

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= qch_pkg::LAST_VERT)
        else $error("vertex count out of range");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && r_cnt != qch_pkg::LAST_VERT) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("vertex count skipped");

    a_hold_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_v && r_o_valid && r_cnt != qch_pkg::LAST_VERT) |=> r_f_v)
        else $error("final stage drained while vertices pending");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && r_cnt == qch_pkg::LAST_VERT && !r_f_v) |=> !r_o_valid)
        else $error("vertex valid held after last transfer");

endmodule
